[sv/fltap_pkg.sv]
// fltap_pkg: shared types and constants for the loadable-tap fir filter
`timescale 1ns / 1ps
package fltap_pkg;

  // item operation codes
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // configuration register indexes
  localparam logic REG_TAP_COUNT    = 1'b0;
  localparam logic REG_OUTPUT_SHIFT = 1'b1;

  // configuration field widths and reset values
  localparam int TAP_COUNT_W = 8;
  localparam int SHIFT_W     = 5;
  localparam int CFG_DATA_W  = 8;
  localparam int COEF_IDX_W  = 7;
  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST    = 8'd101;
  localparam logic [SHIFT_W-1:0]     OUTPUT_SHIFT_RST = 5'd15;

  // width of the post-accumulate rounding datapath
  localparam int RND_W = 64;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_ROUND,
    ST_SHIFT,
    ST_DONE
  } state_t;

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic vld;
  } mac_ctl_t;

endpackage

[sv/fltap_mac.sv]
// fltap_mac: shared multiply-accumulate unit, one product per cycle
`timescale 1ns / 1ps
module fltap_mac
  import fltap_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16,
  parameter int ACC_W        = 39
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mac_ctl_t                       ctl,
  input  logic signed [COEF_WIDTH-1:0]   coef,
  input  logic signed [SAMPLE_WIDTH-1:0] smp,
  output logic signed [ACC_W-1:0]        acc,
  output logic                           busy
);

  localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;

  logic signed [PW-1:0] prod;
  logic                 prod_vld;

  // product register
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctl.vld;
    end
    if (ctl.vld) begin
      prod <= coef * smp;
    end
  end

  // accumulator, wraps at its width
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign busy = prod_vld;

endmodule

[sv/fir_filter_loadable_taps_core.sv]
// fir_filter_loadable_taps_core: direct-form fir filter with a loadable coefficient store
`timescale 1ns / 1ps
// A sample item, once accepted, walks the taps in use (tap_count, with zero read as one
// and capped at MAX_TAPS, further limited to the number of samples seen since reset) on
// the single multiply-accumulate unit, which takes one tap per cycle from the coefficient
// and history memories; a rounding, a shift and a saturation step follow before the
// result is loaded into the output register. A coefficient-write item gives no result
// and leaves the block ready.
// The next item is accepted as soon as the result sits in the output register, even if
// it has not been taken yet. No clearing pass runs after reset: a fill count treats
// history slots not yet written as zero. Coefficients must be written before use.
module fir_filter_loadable_taps_core
  import fltap_pkg::*;
#(
  parameter int MAX_TAPS     = 128,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // input item channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           operation,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  input  logic [COEF_IDX_W-1:0]          coef_index,
  input  logic signed [COEF_WIDTH-1:0]   coef_value,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] filtered_out,
  output logic                           saturated,
  // configuration write port
  input  logic                           cfg_write,
  input  logic                           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data
);

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int CW    = $clog2(MAX_TAPS + 1);
  localparam int SUM_W = SAMPLE_WIDTH + COEF_WIDTH + AW;
  localparam int ACC_W = (SUM_W > RND_W) ? RND_W : SUM_W;
  localparam logic signed [RND_W-1:0] SAT_HI = (RND_W'(1) <<< (SAMPLE_WIDTH - 1)) - RND_W'(1);
  localparam logic signed [RND_W-1:0] SAT_LO = ~SAT_HI;

  // configuration registers
  logic [TAP_COUNT_W-1:0] tap_count;
  logic [SHIFT_W-1:0]     output_shift;

  // storage
  logic signed [SAMPLE_WIDTH-1:0] hist_mem [MAX_TAPS];
  logic signed [COEF_WIDTH-1:0]   coef_mem [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] hist_q;
  logic signed [COEF_WIDTH-1:0]   coef_q;

  // sequencer state
  state_t                 state, state_next;
  logic [AW-1:0]          ptr;
  logic [CW-1:0]          fill;
  logic [CW-1:0]          fill_next;
  logic [CW-1:0]          n_taps;
  logic [CW-1:0]          n_taps_next;
  logic [CW-1:0]          ic;
  logic [AW-1:0]          rd_pos;
  logic                   rd_vld;
  logic                   issue;
  logic                   accept;
  logic                   acc_filter;
  logic                   acc_coef;
  logic                   load_out;

  // post-accumulate datapath
  logic signed [ACC_W-1:0] acc;
  logic                    mac_busy;
  mac_ctl_t                mac_ctl;
  logic signed [RND_W-1:0] rnd_sum;
  logic signed [RND_W-1:0] shifted;
  logic signed [RND_W-1:0] rnd_bias;
  logic                    sat_hi;
  logic                    sat_lo;

  assign accept     = in_valid && in_ready;
  assign acc_filter = accept && (operation == OP_FILTER);
  assign acc_coef   = accept && (operation == OP_COEF);
  assign issue      = (state == ST_MAC) && (ic != n_taps);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count    <= TAP_COUNT_RST;
      output_shift <= OUTPUT_SHIFT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TAP_COUNT:    tap_count    <= cfg_data[TAP_COUNT_W-1:0];
        REG_OUTPUT_SHIFT: output_shift <= cfg_data[SHIFT_W-1:0];
        default:          ;
      endcase
    end
  end

  // taps for this sample: clamp tap_count, limit to filled history
  always_comb begin
    int unsigned t;
    int unsigned f;
    t = 32'(tap_count);
    if (t == 0) t = 1;
    if (t > MAX_TAPS) t = MAX_TAPS;
    f = 32'(fill);
    if (f < MAX_TAPS) f = f + 1;
    if (t > f) t = f;
    fill_next   = CW'(f);
    n_taps_next = CW'(t);
  end

  // coefficient memory
  always_ff @(posedge clk) begin
    if (acc_coef && (32'(coef_index) < MAX_TAPS)) begin
      coef_mem[AW'(coef_index)] <= coef_value;
    end
    if (issue) begin
      coef_q <= coef_mem[ic[AW-1:0]];
    end
  end

  // sample history memory
  always_ff @(posedge clk) begin
    if (acc_filter) begin
      hist_mem[ptr] <= sample_in;
    end
    if (issue) begin
      hist_q <= hist_mem[rd_pos];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (operation == OP_FILTER)) state_next = ST_MAC;
      end
      ST_MAC: begin
        if (!issue && !rd_vld && !mac_busy) state_next = ST_ROUND;
      end
      ST_ROUND: state_next = ST_SHIFT;
      ST_SHIFT: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // pointers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr    <= '0;
      fill   <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (acc_filter) begin
        ptr  <= (ptr == AW'(MAX_TAPS - 1)) ? '0 : ptr + 1'b1;
        fill <= fill_next;
      end
    end
    if (acc_filter) begin
      n_taps <= n_taps_next;
      ic     <= '0;
      rd_pos <= ptr;
    end else if (issue) begin
      ic     <= ic + 1'b1;
      rd_pos <= (rd_pos == '0) ? AW'(MAX_TAPS - 1) : rd_pos - 1'b1;
    end
  end

  // shared multiply-accumulate
  assign mac_ctl.clear = acc_filter;
  assign mac_ctl.vld   = rd_vld;

  fltap_mac #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH),
    .ACC_W       (ACC_W)
  ) u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (mac_ctl),
    .coef(coef_q),
    .smp (hist_q),
    .acc (acc),
    .busy(mac_busy)
  );

  // round to nearest, then arithmetic shift
  assign rnd_bias = (output_shift != '0) ? (RND_W'(1) <<< (output_shift - 1'b1)) : '0;

  always_ff @(posedge clk) begin
    if (state == ST_ROUND) begin
      rnd_sum <= RND_W'(acc) + rnd_bias;
    end
    if (state == ST_SHIFT) begin
      shifted <= rnd_sum >>> output_shift;
    end
  end

  // saturation
  assign sat_hi = shifted > SAT_HI;
  assign sat_lo = shifted < SAT_LO;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      saturated <= sat_hi || sat_lo;
      if (sat_hi) begin
        filtered_out <= SAT_HI[SAMPLE_WIDTH-1:0];
      end else if (sat_lo) begin
        filtered_out <= SAT_LO[SAMPLE_WIDTH-1:0];
      end else begin
        filtered_out <= shifted[SAMPLE_WIDTH-1:0];
      end
    end
  end

  // a filter item makes the block busy in the next cycle
  a_filter_busy: assert property (@(posedge clk) disable iff (rst)
    acc_filter |=> !in_ready)
    else $error("filter item did not start the sequencer");

  // a coefficient write leaves the block ready
  a_coef_ready: assert property (@(posedge clk) disable iff (rst)
    acc_coef |=> in_ready)
    else $error("coefficient write left the block busy");

  // tap walk stays within the taps in use and the filled history
  a_tap_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC) |-> (ic <= n_taps) && (n_taps != '0) && (n_taps <= fill))
    else $error("tap counter out of range");

  // a result is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || out_ready))
    else $error("result overwrote a pending item");

endmodule

[tb/testbench.sv]
// testbench: self-checking randomized testbench for fir_filter_loadable_taps_core
`timescale 1ns / 1ps

module testbench;
  import fltap_pkg::*;

  localparam int TAPS_MAX = 128;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W = 16;
  localparam int SETTLE_CYCLES = 150;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int NUM_PHASES = 10;
  localparam int RANDOM_PER_PHASE = 77;
  localparam int REPORT_CAP = 200;
  localparam longint OUT_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint OUT_MIN = -(longint'(1) <<< (SAMPLE_W - 1));

  // register settings per phase, phase 0 runs on the reset values
  localparam int PHASE_TAPS [NUM_PHASES] = '{101, 1, 0, 2, 8, 128, 255, 16, 4, 32};
  localparam int PHASE_SHIFT [NUM_PHASES] = '{15, 1, 0, 31, 15, 31, 15, 16, 3, 20};

  localparam logic signed [SAMPLE_W-1:0] EXTREMES [4] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff};
  localparam logic signed [SAMPLE_W-1:0] PROBE_SAMPLES [9] =
    '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001,
      16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000};
  localparam logic signed [SAMPLE_W-1:0] TIE_SAMPLES [4] = '{-16'sd3, -16'sd1, 16'sd1, 16'sd3};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       sat;
  } fir_result_t;

  // predicts filter outputs and checks them in order
  class fir_scoreboard;
    logic signed [SAMPLE_W-1:0] history [TAPS_MAX];
    logic signed [COEF_W-1:0]   coefs [TAPS_MAX];
    int unsigned                head;
    logic [TAP_COUNT_W-1:0]     tap_count;
    logic [SHIFT_W-1:0]         out_shift;
    fir_result_t                expected_outputs [$];
    int                         errors;

    function new();
      foreach (history[i]) begin
        history[i] = '0;
        coefs[i] = '0;
      end
      head = 0;
      tap_count = TAP_COUNT_RST;
      out_shift = OUTPUT_SHIFT_RST;
      errors = 0;
    endfunction

    function void write_register(logic index, logic [CFG_DATA_W-1:0] data);
      if (index == REG_TAP_COUNT) begin
        tap_count = data[TAP_COUNT_W-1:0];
      end else begin
        out_shift = data[SHIFT_W-1:0];
      end
    endfunction

    // shift the sample in, multiply-accumulate, round, shift and clip
    function fir_result_t filter_sample(logic signed [SAMPLE_W-1:0] s);
      int          n;
      int          j;
      int unsigned pos;
      longint      acc;
      fir_result_t r;
      history[head] = s;
      if (tap_count == 0) n = 1;
      else if (tap_count > TAPS_MAX) n = TAPS_MAX;
      else n = int'(tap_count);
      acc = 0;
      pos = head;
      for (j = 0; j < n; j++) begin
        acc += longint'(coefs[j]) * longint'(history[pos]);
        pos = (pos == 0) ? TAPS_MAX - 1 : pos - 1;
      end
      head = (head + 1) % TAPS_MAX;
      // round half up at the shift point
      if (out_shift != 0) acc += longint'(1) << (out_shift - 1);
      acc = acc >>> out_shift;
      r.sat = 1'b0;
      if (acc > OUT_MAX) begin
        acc = OUT_MAX;
        r.sat = 1'b1;
      end else if (acc < OUT_MIN) begin
        acc = OUT_MIN;
        r.sat = 1'b1;
      end
      r.value = acc[SAMPLE_W-1:0];
      return r;
    endfunction

    function void note_input(logic op, logic signed [SAMPLE_W-1:0] s,
                             logic [COEF_IDX_W-1:0] idx, logic signed [COEF_W-1:0] c);
      if (op == OP_COEF) begin
        coefs[idx] = c;
      end else begin
        expected_outputs.push_back(filter_sample(s));
      end
    endfunction

    task report(string msg);
      if (errors < REPORT_CAP) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_output(logic signed [SAMPLE_W-1:0] value, logic sat);
      fir_result_t e;
      if (expected_outputs.size() == 0) begin
        report($sformatf("unexpected result %0d sat %0b", value, sat));
        return;
      end
      e = expected_outputs.pop_front();
      if (value !== e.value)
        report($sformatf("filtered_out %0d, expected %0d", value, e.value));
      if (sat !== e.sat)
        report($sformatf("saturated %0b, expected %0b (value %0d)", sat, e.sat, e.value));
    endtask

    function int pending();
      return expected_outputs.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = OP_FILTER;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic [COEF_IDX_W-1:0] coef_index = '0;
  logic signed [COEF_W-1:0] coef_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] filtered_out;
  logic saturated;
  logic cfg_write = 1'b0;
  logic cfg_index = REG_TAP_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int send_idle_pct = 29;
  int recv_idle_pct = 49;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int cycles = 0;

  fir_scoreboard sb = new();

  fir_filter_loadable_taps_core #(
    .MAX_TAPS(TAPS_MAX),
    .SAMPLE_WIDTH(SAMPLE_W),
    .COEF_WIDTH(COEF_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .sample_in(sample_in),
    .coef_index(coef_index),
    .coef_value(coef_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .filtered_out(filtered_out),
    .saturated(saturated),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result receiver with random stalls and requested long holds
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= LONG_HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor both channels
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.note_input(operation, sample_in, coef_index, coef_value);
    if (!rst && out_valid && out_ready)
      sb.check_output(filtered_out, saturated);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** fir_filter_loadable_taps_core: FAILED **");
      $finish;
    end
  end

  task automatic set_idling(int sender_pct, int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct <= receiver_pct;
  endtask

  // offer one item and wait until it is taken
  task automatic send_item(logic op, logic signed [SAMPLE_W-1:0] s,
                           logic [COEF_IDX_W-1:0] idx, logic signed [COEF_W-1:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    sample_in <= s;
    coef_index <= idx;
    coef_value <= c;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
    send_item(OP_FILTER, s, COEF_IDX_W'($urandom), COEF_W'($urandom));
  endtask

  task automatic send_coef(logic [COEF_IDX_W-1:0] idx, logic signed [COEF_W-1:0] c);
    send_item(OP_COEF, SAMPLE_W'($urandom), idx, c);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  task automatic write_config(int taps, int shift);
    cfg_write <= 1'b1;
    cfg_index <= REG_TAP_COUNT;
    cfg_data <= taps[CFG_DATA_W-1:0];
    sb.write_register(REG_TAP_COUNT, taps[CFG_DATA_W-1:0]);
    @(posedge clk);
    cfg_index <= REG_OUTPUT_SHIFT;
    cfg_data <= shift[CFG_DATA_W-1:0];
    sb.write_register(REG_OUTPUT_SHIFT, shift[CFG_DATA_W-1:0]);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // mostly full-range values, some extremes and some near zero
  function automatic logic signed [SAMPLE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return EXTREMES[$urandom_range(0, 3)];
    if (r < 30) return SAMPLE_W'($signed($urandom_range(0, 15)) - 8);
    return SAMPLE_W'($urandom);
  endfunction

  task automatic send_random_item();
    if ($urandom_range(0, 99) < 12)
      send_coef(COEF_IDX_W'($urandom_range(0, TAPS_MAX - 1)), pick_value());
    else send_sample(pick_value());
  endtask

  // stimulus
  initial begin
    int i;
    int p;
    int k;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // every coefficient gets a value before the first sample
    for (i = 0; i < TAPS_MAX; i++) send_coef(COEF_IDX_W'(i), pick_value());

    // extreme coefficients and samples, early samples see empty history
    send_coef(0, 16'sh8000);
    send_coef(TAPS_MAX - 1, 16'sh7fff);
    send_coef(1, 16'sh0000);
    foreach (PROBE_SAMPLES[k]) send_sample(PROBE_SAMPLES[k]);
    for (k = 0; k < RANDOM_PER_PHASE; k++) send_random_item();

    for (p = 1; p < NUM_PHASES; p++) begin
      drain();
      repeat (SETTLE_CYCLES) @(posedge clk);
      if (p >= 7) set_idling(0, 0);
      else if (p >= 4) set_idling(49, 29);
      write_config(PHASE_TAPS[p], PHASE_SHIFT[p]);
      // rounding ties with a unit coefficient
      if (PHASE_SHIFT[p] == 1) begin
        send_coef(0, 16'sd1);
        foreach (TIE_SAMPLES[k]) send_sample(TIE_SAMPLES[k]);
      end
      for (k = 0; k < 4; k++) send_sample(PROBE_SAMPLES[k]);
      for (k = 0; k < RANDOM_PER_PHASE; k++) begin
        if (k == RANDOM_PER_PHASE / 2) begin
          if (p == 2 || p == 7) hold_req <= hold_req + 1;
          if (p == 3) drain();
        end
        send_random_item();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** fir_filter_loadable_taps_core: PASSED **");
    end else begin
      $display("** fir_filter_loadable_taps_core: FAILED **");
    end
    $finish;
  end

endmodule
